/* hdl/ptc_pkg.sv */
// Package for the pressure and temperature compensation block.
// Holds configuration register indexes, reset values and fixed constants.
// No dependencies.
package ptc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_T1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P23   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P45   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P67   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_P89   = 3'd6;

    localparam logic [15:0] RST_T1  = 16'd27504;
    localparam logic [31:0] RST_T23 = 32'd1732508696;
    localparam logic [15:0] RST_P1  = 16'd36477;
    localparam logic [31:0] RST_P23 = 32'd3594718160;
    localparam logic [31:0] RST_P45 = 32'd187105420;
    localparam logic [31:0] RST_P67 = 32'd4294524044;
    localparam logic [31:0] RST_P89 = 32'd3338147696;

    localparam int unsigned DIV_STAGES = 32;
    localparam int unsigned PIPE_DEPTH = 44;

    typedef logic signed [15:0] t_coeff;

endpackage

/* hdl/pressure_temp_compensation.sv */
// Throughput: one item per cycle whenever the output is not stalled.
// The 32-stage restoring divider sets the depth; every stage advances together.
// The pipeline stalls only while the output register holds an item that is stalled.
// Reset is synchronous, active low: it clears the pipeline valid bits (not the
// pressure-valid flags) and loads the calibration registers with their default coefficients.
module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [19:0]          i_raw_temperature,
    input  logic [19:0]          i_raw_pressure,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_temperature_centi,
    output logic [19:0]          o_pressure_pascal,
    output logic                 o_pressure_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int unsigned LAST = PIPE_DEPTH - 1;

    logic [15:0] r_cfg_t1, r_cfg_p1;
    logic [31:0] r_cfg_t23, r_cfg_p23, r_cfg_p45, r_cfg_p67, r_cfg_p89;
    t_coeff c_t2, c_t3, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;

    logic        r_vld [0:LAST];
    logic        r_en;
    logic [19:0] r_rp [0:6];
    logic signed [15:0] r_tc [3:LAST];

    logic signed [17:0] r_x;
    logic signed [16:0] r_d;
    logic signed [33:0] r_m1, r_dd;
    logic signed [22:0] r_at;
    logic signed [37:0] r_m2;
    logic signed [25:0] r_fine, r_pa;
    logic signed [47:0] r_sq;
    logic signed [52:0] r_m3;
    logic signed [41:0] r_m4, r_m6;
    logic signed [50:0] r_m5;
    logic signed [40:0] r_bsh;
    logic signed [31:0] r_c1b;
    logic signed [48:0] r_dprod;
    logic [31:0]        r_nb;

    logic [31:0] r_rem [0:DIV_STAGES];
    logic [31:0] r_num [0:DIV_STAGES];
    logic [31:0] r_quo [0:DIV_STAGES];
    logic [31:0] r_dvs [0:DIV_STAGES];
    logic        r_hi  [0:DIV_STAGES];

    logic [31:0]        r_p1c, r_p2c, r_sqp;
    logic               r_pv1, r_pv2;
    logic signed [46:0] r_m8;
    logic signed [35:0] r_m9;
    logic signed [33:0] r_c2;
    logic [19:0]        r_press;
    logic               r_pvalid;

    logic signed [17:0] n_x;
    logic signed [16:0] n_d;
    logic signed [33:0] n_m1, n_dd;
    logic signed [37:0] n_m2;
    logic signed [25:0] n_fine, n_pa;
    logic signed [15:0] n_tc;
    logic signed [47:0] n_sq;
    logic signed [52:0] n_m3;
    logic signed [41:0] n_m4, n_m6;
    logic signed [50:0] n_m5;
    logic signed [40:0] n_bsh;
    logic signed [31:0] n_c1b;
    logic signed [48:0] n_dprod;
    logic [31:0]        n_nb, n_num, n_dend, n_dvs;
    logic [31:0]        n_rem [0:DIV_STAGES-1];
    logic [31:0]        n_quo [0:DIV_STAGES-1];
    logic [31:0]        n_p, n_sqp;
    logic signed [46:0] n_m8;
    logic signed [35:0] n_m9;
    logic [19:0]        n_press;

    logic signed [28:0] s_tm;
    logic signed [20:0] s_tq;
    logic signed [23:0] s_q;
    logic signed [53:0] s_b0;
    logic signed [52:0] s_b1;
    logic signed [48:0] s_c0;
    logic signed [42:0] s_nb;
    logic signed [35:0] s_f0, s_f1;
    logic signed [36:0] s_fin;

    assign c_t2 = $signed(r_cfg_t23[31:16]);
    assign c_t3 = $signed(r_cfg_t23[15:0]);
    assign c_p2 = $signed(r_cfg_p23[31:16]);
    assign c_p3 = $signed(r_cfg_p23[15:0]);
    assign c_p4 = $signed(r_cfg_p45[31:16]);
    assign c_p5 = $signed(r_cfg_p45[15:0]);
    assign c_p6 = $signed(r_cfg_p67[31:16]);
    assign c_p7 = $signed(r_cfg_p67[15:0]);
    assign c_p8 = $signed(r_cfg_p89[31:16]);
    assign c_p9 = $signed(r_cfg_p89[15:0]);

    assign r_en    = !(r_vld[LAST] && i_stall);
    assign o_stall = !r_en;
    assign o_valid = r_vld[LAST];
    assign o_temperature_centi = r_tc[LAST];
    assign o_pressure_pascal   = r_press;
    assign o_pressure_valid    = r_pvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t1  <= RST_T1;
            r_cfg_t23 <= RST_T23;
            r_cfg_p1  <= RST_P1;
            r_cfg_p23 <= RST_P23;
            r_cfg_p45 <= RST_P45;
            r_cfg_p67 <= RST_P67;
            r_cfg_p89 <= RST_P89;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_T1:  r_cfg_t1  <= i_cfg_data[15:0];
                CFG_T23: r_cfg_t23 <= i_cfg_data;
                CFG_P1:  r_cfg_p1  <= i_cfg_data[15:0];
                CFG_P23: r_cfg_p23 <= i_cfg_data;
                CFG_P45: r_cfg_p45 <= i_cfg_data;
                CFG_P67: r_cfg_p67 <= i_cfg_data;
                CFG_P89: r_cfg_p89 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Temperature path and pressure terms ahead of the divider.
    always_comb begin
        n_x  = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, r_cfg_t1, 1'b0});
        n_d  = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, r_cfg_t1});
        n_m1 = r_x * c_t2;
        n_dd = r_d * r_d;
        n_m2 = $signed(r_dd[33:12]) * c_t3;
        n_fine = 26'(r_at) + 26'($signed(r_m2[37:14]));
        s_tm = 29'(n_fine) * 29'sd5 + 29'sd128;
        s_tq = s_tm[28:8];
        if (s_tq > 21'sd32767) begin
            n_tc = 16'sd32767;
        end else if (s_tq < -21'sd32768) begin
            n_tc = -16'sd32768;
        end else begin
            n_tc = s_tq[15:0];
        end
        n_pa = 26'($signed(r_fine[25:1])) - 26'sd64000;
        s_q  = n_pa[25:2];
        n_sq = s_q * s_q;
        n_m3 = $signed(r_sq[47:11]) * c_p6;
        n_m4 = r_pa * c_p5;
        n_m5 = $signed(r_sq[47:13]) * c_p3;
        n_m6 = r_pa * c_p2;
        s_b0 = 54'(r_m3) + (54'(r_m4) <<< 1);
        s_b1 = 53'(s_b0 >>> 2) + (53'(c_p4) <<< 16);
        n_bsh = s_b1[52:12];
        s_c0 = 49'(r_m5 >>> 3) + 49'(r_m6 >>> 1);
        n_c1b = 32'sd32768 + 32'(s_c0 >>> 18);
        n_dprod = r_c1b * $signed({1'b0, r_cfg_p1});
        s_nb = 43'sd1048576 - 43'($signed({1'b0, r_rp[6]})) - 43'(r_bsh);
        n_nb = s_nb[31:0];
        n_dvs = r_dprod[46:15];
        n_num = r_nb * 32'd3125;
        n_dend = n_num[31] ? n_num : {n_num[30:0], 1'b0};
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [32:0] s_tr;
        logic        s_ge;
        always_comb begin
            s_tr = {r_rem[k], r_num[k][31]};
            s_ge = s_tr >= {1'b0, r_dvs[k]};
            n_rem[k] = s_ge ? 32'(s_tr - {1'b0, r_dvs[k]}) : s_tr[31:0];
            n_quo[k] = {r_quo[k][30:0], s_ge};
        end
    end

    // Correction terms and saturation after the divider.
    always_comb begin
        n_p   = r_hi[DIV_STAGES] ? {r_quo[DIV_STAGES][30:0], 1'b0} : r_quo[DIV_STAGES];
        n_sqp = 32'(n_p[31:3]) * 32'(n_p[31:3]);
        n_m8  = $signed({1'b0, n_p[31:2]}) * c_p8;
        n_m9  = $signed({1'b0, r_sqp[31:13]}) * c_p9;
        s_f0  = 36'(r_m9 >>> 12) + 36'(r_c2) + 36'(c_p7);
        s_f1  = s_f0 >>> 4;
        s_fin = 37'($signed({1'b0, r_p2c})) + 37'(s_f1);
        if (!r_pv2 || s_fin < 37'sd0) begin
            n_press = '0;
        end else if (s_fin > 37'sd1048575) begin
            n_press = 20'd1048575;
        end else begin
            n_press = s_fin[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (r_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_rp[0] <= i_raw_pressure;
            for (int i = 1; i < 7; i++) begin
                r_rp[i] <= r_rp[i-1];
            end
            r_tc[3] <= n_tc;
            for (int i = 4; i < PIPE_DEPTH; i++) begin
                r_tc[i] <= r_tc[i-1];
            end
            r_x     <= n_x;
            r_d     <= n_d;
            r_m1    <= n_m1;
            r_dd    <= n_dd;
            r_at    <= r_m1[33:11];
            r_m2    <= n_m2;
            r_fine  <= n_fine;
            r_pa    <= n_pa;
            r_sq    <= n_sq;
            r_m3    <= n_m3;
            r_m4    <= n_m4;
            r_m5    <= n_m5;
            r_m6    <= n_m6;
            r_bsh   <= n_bsh;
            r_c1b   <= n_c1b;
            r_dprod <= n_dprod;
            r_nb    <= n_nb;
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_num[0] <= n_dend;
            r_dvs[0] <= n_dvs;
            r_hi[0]  <= n_num[31];
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_quo[k+1] <= n_quo[k];
                r_num[k+1] <= {r_num[k][30:0], 1'b0};
                r_dvs[k+1] <= r_dvs[k];
                r_hi[k+1]  <= r_hi[k];
            end
            r_p1c    <= n_p;
            r_sqp    <= n_sqp;
            r_m8     <= n_m8;
            r_pv1    <= (r_dvs[DIV_STAGES] != '0);
            r_p2c    <= r_p1c;
            r_m9     <= n_m9;
            r_c2     <= r_m8[46:13];
            r_pv2    <= r_pv1;
            r_press  <= n_press;
            r_pvalid <= r_pv2;
        end
    end

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pressure_valid |-> o_pressure_pascal == '0)
        else $error("pressure nonzero with invalid divisor");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |=> $stable(r_vld[LAST-1]) && $stable(r_p2c))
        else $error("pipeline moved while stalled");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-4] && r_dvs[DIV_STAGES] != '0 |->
            r_rem[DIV_STAGES] < r_dvs[DIV_STAGES])
        else $error("divider remainder not below divisor");

endmodule

/* dv/tb.sv */
// Testbench for pressure_temp_compensation: drives raw sample pairs with random gaps and stalls.
// Predicts each result with its own integer compensation model and checks each result in order.
// Depends on ptc_pkg and the RTL top level.
module tb;
    import ptc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [19:0]        press;
        logic               pvalid;
    } comp_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = PIPE_DEPTH + 16;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [19:0]          i_raw_temperature = '0;
    logic [19:0]          i_raw_pressure = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [15:0]   o_temperature_centi;
    logic [19:0]          o_pressure_pascal;
    logic                 o_pressure_valid;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    comp_t       expected_q[$];
    int          fail_cnt = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    logic [15:0] cal_t1;
    logic [31:0] cal_t23, cal_p23, cal_p45, cal_p67, cal_p89;
    logic [15:0] cal_p1;

    pressure_temp_compensation DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic comp_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, b, d, fine, temp, q, sq, c1, c2, fin, pl, sqs;
        logic [31:0] num, dvs, p, sq32;
        comp_t r;
        rt = longint'(raw_t); rp = longint'(raw_p);
        t1 = longint'(cal_t1); p1 = longint'(cal_p1);
        t2 = longint'($signed(cal_t23[31:16])); t3 = longint'($signed(cal_t23[15:0]));
        p2 = longint'($signed(cal_p23[31:16])); p3 = longint'($signed(cal_p23[15:0]));
        p4 = longint'($signed(cal_p45[31:16])); p5 = longint'($signed(cal_p45[15:0]));
        p6 = longint'($signed(cal_p67[31:16])); p7 = longint'($signed(cal_p67[15:0]));
        p8 = longint'($signed(cal_p89[31:16])); p9 = longint'($signed(cal_p89[15:0]));
        a = (((rt >>> 3) - t1 * 2) * t2) >>> 11;
        d = (rt >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        fine = a + b;
        temp = (fine * 5 + 128) >>> 8;
        if (temp > 32767) temp = 32767;
        if (temp < -32768) temp = -32768;
        r.temp = temp[15:0];
        r.press = '0;
        r.pvalid = 1'b0;
        a = (fine >>> 1) - 64000;
        q = a >>> 2;
        sq = q * q;
        b = (sq >>> 11) * p6;
        b = b + a * p5 * 2;
        b = (b >>> 2) + p4 * 65536;
        c1 = ((p3 * (sq >>> 13)) >>> 3) + ((p2 * a) >>> 1);
        c1 = c1 >>> 18;
        c1 = ((32768 + c1) * p1) >>> 15;
        dvs = c1[31:0];
        if (dvs != 0) begin
            fin = 1048576 - rp - (b >>> 12);
            num = fin[31:0];
            num = num * 32'd3125;
            if (num < 32'h8000_0000)
                p = (num << 1) / dvs;
            else
                p = (num / dvs) * 32'd2;
            sq32 = (p >> 3) * (p >> 3);
            sqs = longint'(sq32 >> 13);
            c1 = (p9 * sqs) >>> 12;
            pl = longint'(p >> 2);
            c2 = (pl * p8) >>> 13;
            pl = longint'(p);
            fin = pl + ((c1 + c2 + p7) >>> 4);
            if (fin < 0) fin = 0;
            if (fin > 1048575) fin = 1048575;
            r.press = fin[19:0];
            r.pvalid = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_cnt++;
                end else begin
                    comp_t e;
                    e = expected_q.pop_front();
                    if (o_temperature_centi !== e.temp) begin
                        $error("temperature_centi expected %0d actual %0d", e.temp,
                               o_temperature_centi);
                        fail_cnt++;
                    end
                    if (o_pressure_pascal !== e.press) begin
                        $error("pressure_pascal expected %0d actual %0d", e.press,
                               o_pressure_pascal);
                        fail_cnt++;
                    end
                    if (o_pressure_valid !== e.pvalid) begin
                        $error("pressure_valid expected %0d actual %0d", e.pvalid,
                               o_pressure_valid);
                        fail_cnt++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 5) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [19:0] raw_t, logic [19:0] raw_p);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure <= raw_p;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(compensate(raw_t, raw_p));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_T1:  cal_t1 = data[15:0];
            CFG_T23: cal_t23 = data;
            CFG_P1:  cal_p1 = data[15:0];
            CFG_P23: cal_p23 = data;
            CFG_P45: cal_p45 = data;
            CFG_P67: cal_p67 = data;
            CFG_P89: cal_p89 = data;
            default: ;
        endcase
    endtask

    task automatic load_cal(logic [31:0] t1, logic [31:0] t23, logic [31:0] p1,
                            logic [31:0] p23, logic [31:0] p45, logic [31:0] p67,
                            logic [31:0] p89);
        wait_drained();
        write_cal(CFG_T1, t1);
        write_cal(CFG_T23, t23);
        write_cal(CFG_P1, p1);
        write_cal(CFG_P23, p23);
        write_cal(CFG_P45, p45);
        write_cal(CFG_P67, p67);
        write_cal(CFG_P89, p89);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
        end
    endtask

    task automatic test_field_extremes();
        logic [19:0] vals[6] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF,
                                 20'd519888, 20'd415148};
        foreach (vals[i]) send_item(vals[i], vals[(i + 3) % 6]);
        send_item(20'd519888, 20'd415148);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
    endtask

    task automatic test_zero_divisor();
        load_cal(32'(RST_T1), RST_T23, 32'hFFFF_0000, RST_P23, RST_P45, RST_P67, RST_P89);
        send_item(20'd519888, 20'd415148);
        send_item(20'hFFFFF, 20'h00000);
        send_random(40);
    endtask

    task automatic test_saturation();
        load_cal(32'h0, 32'h7FFF_7FFF, 32'(RST_P1), RST_P23, RST_P45, RST_P67, RST_P89);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'h00000, 20'hFFFFF);
        load_cal(32'hFFFF, 32'h7FFF_8000, 32'h0001, 32'h8000_7FFF, 32'h8000_8000,
                 32'h7FFF_8000, 32'h8000_7FFF);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_random(60);
    endtask

    task automatic test_cal_extremes();
        load_cal(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_random(40);
        load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random(40);
        load_cal(32'h8000, 32'h8000_8000, 32'h8000, 32'h8000_8000, 32'h8000_8000,
                 32'h8000_8000, 32'h8000_8000);
        send_random(40);
        load_cal(32'h7FFF, 32'h7FFF_7FFF, 32'h7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_random(40);
    endtask

    task automatic test_unused_index();
        load_cal(32'(RST_T1), RST_T23, 32'(RST_P1), RST_P23, RST_P45, RST_P67, RST_P89);
        write_cal(3'd7, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_random(30);
    endtask

    task automatic test_random_cal();
        for (int k = 0; k < 6; k++) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_random(60);
        end
    endtask

    task automatic test_default_cal_bulk();
        load_cal(32'(RST_T1), RST_T23, 32'(RST_P1), RST_P23, RST_P45, RST_P67, RST_P89);
        send_random(500);
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        send_random(700);
    endtask

    initial begin
        cal_t1 = RST_T1; cal_t23 = RST_T23; cal_p1 = RST_P1; cal_p23 = RST_P23;
        cal_p45 = RST_P45; cal_p67 = RST_P67; cal_p89 = RST_P89;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_zero_divisor();
        test_saturation();
        test_cal_extremes();
        test_unused_index();
        test_random_cal();
        test_default_cal_bulk();
        wait_drained();
        if (fail_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
